FILE: rtl/ssel_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state encoding for the subset-sum select unit.
package ssel_pkg;

   localparam int MAX_ITEMS    = 32;
   localparam int MAX_CAPACITY = 63;

   localparam int SIZE_W    = 7;
   localparam int SUM_W     = 6;
   localparam int ROW_W     = 1 << SUM_W;
   localparam int MASK_W    = 32;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int ITEM_AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int REQ_DATA_W = ((SIZE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SUM_W + MASK_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      S_ACCEPT,
      S_SEARCH,
      S_PRIME,
      S_WALK,
      S_FINISH
   } ssel_state_type;

   typedef struct packed {
      logic item_take;
      logic search_step;
      logic walk_init;
      logic walk_issue;
      logic walk_eval;
      logic result_load;
   } ssel_cmd_type;

   typedef struct packed {
      logic search_hit;
      logic walk_end;
      logic out_free;
   } ssel_status_type;

endpackage

FILE: rtl/ssel_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing item intake, sum search, backward walk and result load.
module ssel_ctrl
   import ssel_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tlast,
   output logic            req_tready,
   input  ssel_status_type status,
   output ssel_cmd_type    cmd
);

   ssel_state_type state_ff;
   ssel_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_ACCEPT: begin
            if (req_tvalid && req_tlast) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (status.search_hit) begin
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (status.walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               state_in = S_ACCEPT;
            end
         end
         default: begin
            state_in = S_ACCEPT;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_ACCEPT: begin
            req_tready    = 1'b1;
            cmd.item_take = req_tvalid;
         end
         S_SEARCH: begin
            cmd.search_step = !status.search_hit;
            cmd.walk_init   = status.search_hit;
         end
         S_PRIME: begin
            cmd.walk_issue = 1'b1;
         end
         S_WALK: begin
            cmd.walk_eval  = 1'b1;
            cmd.walk_issue = !status.walk_end;
         end
         S_FINISH: begin
            cmd.result_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/ssel_dpath.sv
`timescale 1ns / 1ps
// Datapath: reachability rows, size store, sum search, backward walk and result register.
module ssel_dpath
   import ssel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ssel_cmd_type          cmd,
   output ssel_status_type       status,
   input  logic [SIZE_W-1:0]     item_size,
   input  logic                  item_last,
   input  logic                  csr_wr_en,
   input  logic [SUM_W-1:0]      csr_wr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [SUM_W-1:0]      rsp_best_sum,
   output logic [MASK_W-1:0]     rsp_chosen_mask,
   output logic                  rsp_overflow
);

   // Row k+1 of the set lives at row_mem[k]; row zero is the constant one.
   logic [ROW_W-1:0]  row_mem  [MAX_ITEMS];
   logic [SIZE_W-1:0] size_mem [MAX_ITEMS];

   logic [SUM_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   items_held_ff;
   logic               overflow_seen_ff;
   logic [ROW_W-1:0]   cur_row_ff;
   logic [SUM_W-1:0]   best_ff;
   logic [SUM_W-1:0]   rem_ff;
   logic [CNT_W-1:0]   walk_i_ff;
   logic [ITEM_AW-1:0] eval_k_ff;
   logic               eval_k_zero_ff;
   logic [SIZE_W-1:0]  size_rd_ff;
   logic [ROW_W-1:0]   row_rd_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic               rsp_valid_ff;
   logic [SUM_W-1:0]   rsp_best_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic               rsp_overflow_ff;

   logic [SUM_W-1:0]   cap_eff;
   logic [ROW_W-1:0]   cap_mask;
   logic [ROW_W-1:0]   row_new;
   logic               can_store;
   logic [CNT_W-1:0]   walk_k;
   logic [ROW_W-1:0]   row_k;
   logic [SIZE_W-1:0]  rem_wide;
   logic [SIZE_W-1:0]  diff;
   logic               take;
   logic [SUM_W-1:0]   rem_in;
   logic [MASK_W-1:0]  mask_in;

   always_comb begin
      cap_eff = (capacity_ff > SUM_W'(MAX_CAPACITY)) ? SUM_W'(MAX_CAPACITY) : capacity_ff;
      for (int t = 0; t < ROW_W; t++) begin
         cap_mask[t] = (SUM_W'(t) <= cap_eff);
      end
      row_new   = (cur_row_ff | (cur_row_ff << item_size)) & cap_mask;
      can_store = (items_held_ff < CNT_W'(MAX_ITEMS));
      walk_k    = walk_i_ff - CNT_W'(1);
   end

   // One walk step: take item k if the remainder less its size was reachable before it.
   always_comb begin
      row_k    = eval_k_zero_ff ? ROW_W'(1) : row_rd_ff;
      rem_wide = SIZE_W'(rem_ff);
      diff     = rem_wide - size_rd_ff;
      take     = (rem_wide >= size_rd_ff) && row_k[diff[SUM_W-1:0]];
      rem_in   = take ? diff[SUM_W-1:0] : rem_ff;
      mask_in  = mask_ff;
      for (int j = 0; j < MASK_W; j++) begin
         if ((j < MAX_ITEMS) && take && (eval_k_ff == ITEM_AW'(j))) begin
            mask_in[j] = 1'b1;
         end
      end
   end

   always_comb begin
      status.search_hit = (best_ff == '0) || cur_row_ff[best_ff];
      status.walk_end   = (eval_k_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.item_take && can_store) begin
         row_mem[items_held_ff[ITEM_AW-1:0]]  <= row_new;
         size_mem[items_held_ff[ITEM_AW-1:0]] <= item_size;
      end
      if (cmd.walk_issue) begin
         size_rd_ff <= size_mem[walk_k[ITEM_AW-1:0]];
         row_rd_ff  <= row_mem[walk_k[ITEM_AW-1:0] - ITEM_AW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff      <= SUM_W'(MAX_CAPACITY);
         items_held_ff    <= '0;
         overflow_seen_ff <= 1'b0;
         cur_row_ff       <= ROW_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.result_load) begin
            items_held_ff    <= '0;
            overflow_seen_ff <= 1'b0;
            cur_row_ff       <= ROW_W'(1);
         end else if (cmd.item_take) begin
            if (can_store) begin
               cur_row_ff    <= row_new;
               items_held_ff <= items_held_ff + CNT_W'(1);
            end else begin
               overflow_seen_ff <= 1'b1;
            end
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_take && item_last) begin
         best_ff <= cap_eff;
      end else if (cmd.search_step) begin
         best_ff <= best_ff - SUM_W'(1);
      end
      if (cmd.walk_init) begin
         rem_ff    <= best_ff;
         walk_i_ff <= items_held_ff;
         mask_ff   <= '0;
      end else begin
         if (cmd.walk_issue) begin
            walk_i_ff      <= walk_k;
            eval_k_ff      <= walk_k[ITEM_AW-1:0];
            eval_k_zero_ff <= (walk_k == '0);
         end
         if (cmd.walk_eval) begin
            rem_ff  <= rem_in;
            mask_ff <= mask_in;
         end
      end
      if (cmd.result_load) begin
         rsp_best_ff     <= best_ff;
         rsp_mask_ff     <= mask_ff;
         rsp_overflow_ff <= overflow_seen_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_sum    = rsp_best_ff;
   assign rsp_chosen_mask = rsp_mask_ff;
   assign rsp_overflow    = rsp_overflow_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      items_held_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count above store depth");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_rem_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_eval && !cmd.walk_init) |=> (rem_ff <= $past(rem_ff)))
      else $error("walk remainder grew");

   a_walk_has_items: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_init |-> (items_held_ff != '0))
      else $error("walk started with an empty set");

   a_search_within_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_init |-> (best_ff <= cap_eff))
      else $error("best sum above capacity");
`endif

endmodule

FILE: rtl/subset_sum_select_unit.sv
`timescale 1ns / 1ps
// Items stream at one per cycle while the unit is accepting; after the last item it takes
// none until the result load. The sum search counts down from the capacity to the best sum,
// then come a read-prime state, the backward walk over the held items and the load, which
// waits for a free output register; the result shows in the cycle after the load. The search
// tests one row bit per cycle, the walk one item per cycle. Reset (synchronous, active high)
// empties the set, clears overflow and the result valid flag and sets capacity to its maximum.
module subset_sum_select_unit
   import ssel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input transactions: one item size per transaction.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [6:0] item_size, upper bits zero
   input  logic                  req_tlast,   // last_item
   // Result transactions: one per set.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] best_sum, [37:6] chosen_mask, rest zero
   output logic                  rsp_tuser,   // overflow
   // Capacity register write.
   input  logic                  csr_wr_en,
   input  logic [SUM_W-1:0]      csr_wr_data
);

   ssel_cmd_type    cmd;
   ssel_status_type status;

   logic [SUM_W-1:0]  best_sum;
   logic [MASK_W-1:0] chosen_mask;

   // The controller only sequences; all set state and the result register live in the datapath.
   // A finished result waits in the output register while the next set is already being taken,
   // and the walk of that next set holds in its final state until the register is free.
   ssel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ssel_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .item_size       (req_tdata[SIZE_W-1:0]),
      .item_last       (req_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_best_sum    (best_sum),
      .rsp_chosen_mask (chosen_mask),
      .rsp_overflow    (rsp_tuser)
   );

   // Pack the result fields, lowest field first, padded with zeros to whole bytes.
   assign rsp_tdata = RSP_DATA_W'({chosen_mask, best_sum});

endmodule
